>>> sv/nlst_pkg.sv
// Shared constants, types and register indexes of the NTSC line sync timing block.
package nlst_pkg;

	localparam int H_PIXELS    = 128;
	localparam int V_LINES     = 240;
	localparam int FRAME_LINES = 262;

	localparam int TICK_W = 12;
	localparam int LINE_W = $clog2(FRAME_LINES + 1);
	localparam int COL_W  = 8;
	localparam int SUB_W  = 4;
	localparam int ROW_W  = 8;
	localparam int PCOL_W = 7;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 12;

	// vsync line layout
	localparam int EQ_PRE_LAST     = 3;
	localparam int BROAD_FIRST     = 4;
	localparam int BROAD_LAST      = 6;
	localparam int EQ_POST_LAST    = 9;
	localparam int FIRST_PIC_LINE  = 10;

	// register indexes
	localparam logic [IDX_W-1:0] REG_LINE_PERIOD  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HSYNC_WIDTH  = 3'd1;
	localparam logic [IDX_W-1:0] REG_SHORT_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BROAD_WIDTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_HALF_OFFSET  = 3'd4;
	localparam logic [IDX_W-1:0] REG_ACTIVE_START = 3'd5;
	localparam logic [IDX_W-1:0] REG_PIXEL_TICKS  = 3'd6;
	localparam logic [IDX_W-1:0] REG_FIRST_LINE   = 3'd7;

	typedef struct packed {
		logic [TICK_W-1:0] line_period;
		logic [TICK_W-1:0] hsync_width;
		logic [TICK_W-1:0] short_pulse_width;
		logic [TICK_W-1:0] broad_pulse_width;
		logic [TICK_W-1:0] half_line_offset;
		logic [TICK_W-1:0] active_start;
		logic [SUB_W-1:0]  pixel_ticks;
		logic [LINE_W-1:0] first_active_line;
	} cfg_t;

	typedef struct packed {
		logic              sync_level;
		logic [LINE_W-1:0] line_number;
		logic              in_active;
		logic [ROW_W-1:0]  pixel_row;
		logic [PCOL_W-1:0] pixel_col;
		logic              line_start;
	} res_t;

endpackage

>>> sv/ntsc_line_sync_timing.sv
// Top level of the NTSC composite sync and pixel timing generator.
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+----------------------------
//   in      | in_valid, in_ready, advance               | one timebase tick or a hold
//   out     | out_valid, out_ready, sync_level ..       | timing of the tick taken
//   cfg     | cfg_we, cfg_index, cfg_wdata              | one register write
//
// One transaction per clock while the output is not stalled: the result of a tick is loaded
// into the output register at the accepting edge and shows on the ports the cycle after;
// the counters step at that same edge when advance is high.
// in_ready is high while the output register is empty or being drained.
// Reset loads the default timing registers and starts at line 1, tick 0.
// A stalled result holds in the output register; no new input is taken then.
module ntsc_line_sync_timing
	import nlst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              sync_level,
	output logic [LINE_W-1:0] line_number,
	output logic              in_active,
	output logic [ROW_W-1:0]  pixel_row,
	output logic [PCOL_W-1:0] pixel_col,
	output logic              line_start,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	nlst_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	nlst_timing u_timing (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (accept && advance),
		.cfg   (cfg),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// capture the result of the current tick before the counters move
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign sync_level  = res_q.sync_level;
	assign line_number = res_q.line_number;
	assign in_active   = res_q.in_active;
	assign pixel_row   = res_q.pixel_row;
	assign pixel_col   = res_q.pixel_col;
	assign line_start  = res_q.line_start;

endmodule

>>> sv/nlst_cfg_regs.sv
// Configuration register file of the NTSC line sync timing block.
module nlst_cfg_regs
	import nlst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_period       <= TICK_W'(1017);
			cfg_q.hsync_width       <= TICK_W'(64);
			cfg_q.short_pulse_width <= TICK_W'(32);
			cfg_q.broad_pulse_width <= TICK_W'(432);
			cfg_q.half_line_offset  <= TICK_W'(496);
			cfg_q.active_start      <= TICK_W'(128);
			cfg_q.pixel_ticks       <= SUB_W'(4);
			cfg_q.first_active_line <= LINE_W'(20);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_PERIOD:  cfg_q.line_period       <= cfg_wdata[TICK_W-1:0];
				REG_HSYNC_WIDTH:  cfg_q.hsync_width       <= cfg_wdata[TICK_W-1:0];
				REG_SHORT_WIDTH:  cfg_q.short_pulse_width <= cfg_wdata[TICK_W-1:0];
				REG_BROAD_WIDTH:  cfg_q.broad_pulse_width <= cfg_wdata[TICK_W-1:0];
				REG_HALF_OFFSET:  cfg_q.half_line_offset  <= cfg_wdata[TICK_W-1:0];
				REG_ACTIVE_START: cfg_q.active_start      <= cfg_wdata[TICK_W-1:0];
				REG_PIXEL_TICKS:  cfg_q.pixel_ticks       <= cfg_wdata[SUB_W-1:0];
				REG_FIRST_LINE:   cfg_q.first_active_line <= cfg_wdata[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/nlst_timing.sv
// Line and pixel counters with sync and window decode for the current tick.
module nlst_timing
	import nlst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cfg_t cfg,
	output res_t res
);

	logic [LINE_W-1:0] line_q;
	logic [TICK_W-1:0] tick_q;
	logic [SUB_W-1:0]  sub_q;
	logic [COL_W-1:0]  col_q;

	logic              eq_line, broad_line, low;
	logic [TICK_W-1:0] pulse_w;
	logic [TICK_W:0]   second_end;
	logic [LINE_W-1:0] row_diff;
	logic              act;
	logic [SUB_W-1:0]  pt;
	logic [SUB_W:0]    sub_inc;
	logic [TICK_W:0]   tick_inc;
	logic              line_end, pixel_done;

	// sync decode
	always_comb begin
		eq_line    = (line_q >= LINE_W'(1) && line_q <= LINE_W'(EQ_PRE_LAST)) ||
		             (line_q > LINE_W'(BROAD_LAST) && line_q <= LINE_W'(EQ_POST_LAST));
		broad_line = line_q >= LINE_W'(BROAD_FIRST) && line_q <= LINE_W'(BROAD_LAST);
		pulse_w    = broad_line ? cfg.broad_pulse_width : cfg.short_pulse_width;
		second_end = {1'b0, cfg.half_line_offset} + {1'b0, pulse_w};
		if (eq_line || broad_line) begin
			low = (tick_q < pulse_w) ||
			      (tick_q >= cfg.half_line_offset && {1'b0, tick_q} < second_end);
		end else begin
			low = tick_q < cfg.hsync_width;
		end
	end

	// pixel window
	always_comb begin
		row_diff = line_q - cfg.first_active_line;
		act = (line_q >= LINE_W'(FIRST_PIC_LINE)) && (line_q >= cfg.first_active_line) &&
		      (row_diff < LINE_W'(V_LINES)) && (tick_q >= cfg.active_start) &&
		      (col_q < COL_W'(H_PIXELS));
	end

	always_comb begin
		res.sync_level  = ~low;
		res.line_number = line_q;
		res.in_active   = act;
		res.pixel_row   = act ? row_diff[ROW_W-1:0] : '0;
		res.pixel_col   = act ? col_q[PCOL_W-1:0] : '0;
		res.line_start  = (tick_q == '0);
	end

	always_comb begin
		pt         = (cfg.pixel_ticks == '0) ? SUB_W'(1) : cfg.pixel_ticks;
		sub_inc    = {1'b0, sub_q} + (SUB_W+1)'(1);
		pixel_done = sub_inc >= {1'b0, pt};
		tick_inc   = {1'b0, tick_q} + (TICK_W+1)'(1);
		line_end   = tick_inc >= {1'b0, cfg.line_period};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_W'(1);
			tick_q <= '0;
			sub_q  <= '0;
			col_q  <= '0;
		end else if (step) begin
			if (line_end) begin
				tick_q <= '0;
				sub_q  <= '0;
				col_q  <= '0;
				line_q <= (line_q >= LINE_W'(FRAME_LINES)) ? LINE_W'(1) : line_q + LINE_W'(1);
			end else begin
				tick_q <= tick_inc[TICK_W-1:0];
				if (act) begin
					if (pixel_done) begin
						sub_q <= '0;
						col_q <= col_q + COL_W'(1);
					end else begin
						sub_q <= sub_inc[SUB_W-1:0];
					end
				end
			end
		end
	end

endmodule

>>> sv/nlst_checker.sv
// Port-level checker of the NTSC line sync timing block, with its bind.
module nlst_checker
	import nlst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              sync_level,
	input logic [LINE_W-1:0] line_number,
	input logic              in_active,
	input logic [ROW_W-1:0]  pixel_row,
	input logic [PCOL_W-1:0] pixel_col,
	input logic              line_start
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_number) &&
		$stable(sync_level) && $stable(pixel_row) && $stable(pixel_col) &&
		$stable(in_active) && $stable(line_start))
		else $error("stalled result changed");

	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number >= LINE_W'(1) && line_number <= LINE_W'(FRAME_LINES))
		else $error("line number out of range");

	a_window_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_active |-> line_number >= LINE_W'(FIRST_PIC_LINE) &&
		pixel_row < ROW_W'(V_LINES))
		else $error("pixel window open on a blanked line");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_active |-> pixel_row == '0 && pixel_col == '0)
		else $error("pixel position set outside the window");

endmodule

bind ntsc_line_sync_timing nlst_checker u_nlst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sync_level (sync_level),
	.line_number(line_number),
	.in_active  (in_active),
	.pixel_row  (pixel_row),
	.pixel_col  (pixel_col),
	.line_start (line_start)
);
